/* rtl/bab_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bab_pkg
// Shared types and constants of the block average binarizer.
// ----------------------------------------------------------------------------
package bab_pkg;

   localparam int MAX_GRID_COLS = 256;
   localparam int MAX_IMAGE_DIM = 4096;
   localparam int ROW_CAP       = 256;

   localparam int DIM_W  = 13;
   localparam int GRID_W = 9;
   localparam int COL_AW = $clog2(MAX_GRID_COLS);
   localparam int ROW_W  = $clog2(ROW_CAP);
   localparam int POS_W  = $clog2(MAX_IMAGE_DIM);
   localparam int SUM_W  = 34;
   localparam int ERR_W  = DIM_W + 2;
   localparam int IDX_W  = 16;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_GRID_COLS    = 3'd2;
   localparam logic [2:0] CSR_GRID_ROWS    = 3'd3;
   localparam logic [2:0] CSR_COLOR_MODE   = 3'd4;
   localparam logic [2:0] CSR_THRESHOLD    = 3'd5;
   localparam logic [2:0] CSR_COUNT        = 3'd6;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic             cell_bit;
      logic [IDX_W-1:0] cell_index;
      logic             last_cell;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/block_average_binarizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// block_average_binarizer
// Box downsampling of a raster pixel stream with threshold binarization.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while req_stall is low. Each pixel adds
// (luminance - threshold) into a per-cell-column partial sum held in a
// 256 x 34 bit RAM, read as the pixel is accepted and written back in the
// next stage, with the fresh sum forwarded when two beats in a row hit the
// same column. A cell result forms in stage 1 and is then held in the
// output register. req_stall rises only while a stalled result sits in
// the output register and the pipeline holds another cell-closing pixel.
// Each config write restarts the stream at the first pixel of a new image.
module block_average_binarizer (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  bab_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output bab_pkg::rsp_type  rsp_data,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire [bab_pkg::ADDR_W-1:0] paddr,
   input  wire [bab_pkg::DATA_W-1:0] pwdata,
   output logic [bab_pkg::DATA_W-1:0] prdata,
   output logic              pready
);
   import bab_pkg::*;

   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [GRID_W-1:0] cols_cfg_ff, rows_cfg_ff;
   logic              color_ff;
   logic [7:0]        thresh_ff;

   logic [POS_W-1:0]  pixel_x_ff, pixel_x_in, pixel_y_ff, pixel_y_in;
   logic [COL_AW-1:0] cell_col_ff, cell_col_in;
   logic [ROW_W-1:0]  cell_row_ff, cell_row_in;
   logic [IDX_W-1:0]  row_base_ff, row_base_in;
   logic signed [ERR_W-1:0] col_err_ff, col_err_in, row_err_ff, row_err_in;
   logic              first_ff, first_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [COL_AW-1:0] s1_addr_ff;
   logic signed [9:0] s1_delta_ff;
   logic              s1_first_ff, s1_fwd_ff, s1_emit_ff, s1_last_ff;
   logic [IDX_W-1:0]  s1_index_ff;

   logic signed [SUM_W-1:0] rd_ff, wsum_ff;
   logic signed [SUM_W-1:0] sum_mem [MAX_GRID_COLS];

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   logic [DIM_W-1:0]  w_eff, h_eff;
   logic [GRID_W-1:0] cols_cap, rows_cap, cols_eff, rows_eff;
   logic signed [ERR_W-1:0] col_init, row_init, col_test, row_test;
   logic              cfg_write, cfg_restart, accept;
   logic              col_end, row_end, x_last, y_last;
   logic [9:0]        chan_sum;
   logic [20:0]       third;
   logic [7:0]        lum;
   logic signed [9:0] delta;
   logic signed [SUM_W-1:0] base, sum;
   logic              s1_hold, s1_fire;
   logic [2:0]        reg_index;

   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_IMAGE_DIM);

   always_comb begin
      w_eff = (width_ff == '0) ? DIM_W'(1) : ((width_ff > DIM_MAX) ? DIM_MAX : width_ff);
      h_eff = (height_ff == '0) ? DIM_W'(1) : ((height_ff > DIM_MAX) ? DIM_MAX : height_ff);
      cols_cap = (cols_cfg_ff == '0) ? GRID_W'(1) :
                 ((cols_cfg_ff > GRID_W'(MAX_GRID_COLS)) ? GRID_W'(MAX_GRID_COLS) : cols_cfg_ff);
      rows_cap = (rows_cfg_ff == '0) ? GRID_W'(1) :
                 ((rows_cfg_ff > GRID_W'(ROW_CAP)) ? GRID_W'(ROW_CAP) : rows_cfg_ff);
      cols_eff = (DIM_W'(cols_cap) > w_eff) ? w_eff[GRID_W-1:0] : cols_cap;
      rows_eff = (DIM_W'(rows_cap) > h_eff) ? h_eff[GRID_W-1:0] : rows_cap;
      col_init = $signed({1'b0, cols_eff, 1'b0} - ERR_W'(w_eff));
      row_init = $signed({1'b0, rows_eff, 1'b0} - ERR_W'(h_eff));
   end

   assign reg_index   = paddr[ADDR_W-1:2];
   assign pready      = 1'b1;
   assign cfg_write   = psel & penable & pwrite & pready;
   assign cfg_restart = cfg_write & (reg_index < CSR_COUNT);

   always_comb begin
      unique case (reg_index)
         CSR_IMAGE_WIDTH:  prdata = DATA_W'(width_ff);
         CSR_IMAGE_HEIGHT: prdata = DATA_W'(height_ff);
         CSR_GRID_COLS:    prdata = DATA_W'(cols_cfg_ff);
         CSR_GRID_ROWS:    prdata = DATA_W'(rows_cfg_ff);
         CSR_COLOR_MODE:   prdata = DATA_W'(color_ff);
         CSR_THRESHOLD:    prdata = DATA_W'(thresh_ff);
         default:          prdata = '0;
      endcase
   end

   assign s1_hold   = s1_valid_ff & s1_emit_ff & rsp_valid_ff & rsp_stall;
   assign s1_fire   = s1_valid_ff & ~s1_hold;
   assign req_stall = s1_hold;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      col_test = col_err_ff + col_init;
      row_test = row_err_ff + row_init;
      col_end  = col_test > 0;
      row_end  = row_test > 0;
      x_last   = (DIM_W'(pixel_x_ff) + DIM_W'(1)) == w_eff;
      y_last   = (DIM_W'(pixel_y_ff) + DIM_W'(1)) == h_eff;
      chan_sum = 10'(req_data.red) + 10'(req_data.green) + 10'(req_data.blue);
      third    = 21'(chan_sum) * 21'd683;
      lum      = color_ff ? third[18:11] : req_data.red;
      delta    = $signed({2'b00, lum}) - $signed({2'b00, thresh_ff});
      base     = s1_first_ff ? '0 : (s1_fwd_ff ? wsum_ff : rd_ff);
      sum      = base + SUM_W'(s1_delta_ff);
   end

   always_comb begin
      pixel_x_in  = pixel_x_ff;
      pixel_y_in  = pixel_y_ff;
      cell_col_in = cell_col_ff;
      cell_row_in = cell_row_ff;
      row_base_in = row_base_ff;
      col_err_in  = col_err_ff;
      row_err_in  = row_err_ff;
      first_in    = first_ff;
      if (cfg_restart || (accept && x_last && y_last)) begin
         pixel_x_in  = '0;
         pixel_y_in  = '0;
         cell_col_in = '0;
         cell_row_in = '0;
         row_base_in = '0;
         col_err_in  = '0;
         row_err_in  = '0;
         first_in    = 1'b1;
      end else if (accept && x_last) begin
         pixel_x_in  = '0;
         pixel_y_in  = pixel_y_ff + POS_W'(1);
         cell_col_in = '0;
         col_err_in  = '0;
         first_in    = row_end;
         if (row_end) begin
            cell_row_in = cell_row_ff + ROW_W'(1);
            row_base_in = row_base_ff + IDX_W'(cols_eff);
            row_err_in  = row_err_ff + ERR_W'(rows_eff) - ERR_W'(h_eff);
         end else begin
            row_err_in  = row_err_ff + ERR_W'(rows_eff);
         end
      end else if (accept) begin
         pixel_x_in = pixel_x_ff + POS_W'(1);
         if (col_end) begin
            cell_col_in = cell_col_ff + COL_AW'(1);
            col_err_in  = col_err_ff + ERR_W'(cols_eff) - ERR_W'(w_eff);
         end else begin
            col_err_in  = col_err_ff + ERR_W'(cols_eff);
         end
      end
   end

   assign s1_valid_in  = accept | (s1_valid_ff & s1_hold);
   assign rsp_valid_in = (s1_fire & s1_emit_ff) | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DIM_W'(64);
         height_ff    <= DIM_W'(64);
         cols_cfg_ff  <= GRID_W'(16);
         rows_cfg_ff  <= GRID_W'(16);
         color_ff     <= 1'b1;
         thresh_ff    <= 8'd128;
         pixel_x_ff   <= '0;
         pixel_y_ff   <= '0;
         cell_col_ff  <= '0;
         cell_row_ff  <= '0;
         row_base_ff  <= '0;
         col_err_ff   <= '0;
         row_err_ff   <= '0;
         first_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_write) begin
            unique case (reg_index)
               CSR_IMAGE_WIDTH:  width_ff    <= pwdata[DIM_W-1:0];
               CSR_IMAGE_HEIGHT: height_ff   <= pwdata[DIM_W-1:0];
               CSR_GRID_COLS:    cols_cfg_ff <= pwdata[GRID_W-1:0];
               CSR_GRID_ROWS:    rows_cfg_ff <= pwdata[GRID_W-1:0];
               CSR_COLOR_MODE:   color_ff    <= pwdata[0];
               CSR_THRESHOLD:    thresh_ff   <= pwdata[7:0];
               default: ;
            endcase
         end
         pixel_x_ff   <= pixel_x_in;
         pixel_y_ff   <= pixel_y_in;
         cell_col_ff  <= cell_col_in;
         cell_row_ff  <= cell_row_in;
         row_base_ff  <= row_base_in;
         col_err_ff   <= col_err_in;
         row_err_ff   <= row_err_in;
         first_ff     <= first_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff  <= cell_col_ff;
         s1_delta_ff <= delta;
         s1_first_ff <= first_ff;
         s1_fwd_ff   <= s1_valid_ff & (s1_addr_ff == cell_col_ff);
         s1_emit_ff  <= col_end & row_end;
         s1_index_ff <= row_base_ff + IDX_W'(cell_col_ff);
         s1_last_ff  <= ((ROW_W + 1)'(cell_row_ff) + (ROW_W + 1)'(1) == (ROW_W + 1)'(rows_eff)) &&
                        (GRID_W'(cell_col_ff) + GRID_W'(1) == cols_eff);
         rd_ff       <= sum_mem[cell_col_ff];
      end
      if (s1_fire) begin
         sum_mem[s1_addr_ff] <= sum;
         wsum_ff             <= sum;
      end
      if (s1_fire && s1_emit_ff) begin
         rsp_data_ff.cell_bit   <= sum > 0;
         rsp_data_ff.cell_index <= s1_index_ff;
         rsp_data_ff.last_cell  <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* rtl/bab_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bab_checker
// Port-level checks of the block average binarizer, bound to the top level.
// ----------------------------------------------------------------------------
module bab_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_stall,
   input wire              rsp_valid,
   input wire              rsp_stall,
   input bab_pkg::rsp_type rsp_data,
   input wire              psel,
   input wire              penable,
   input wire              pwrite,
   input wire [bab_pkg::ADDR_W-1:0] paddr,
   input wire              pready
);
   import bab_pkg::*;

   logic [IDX_W-1:0] next_index_ff, next_index_in;
   logic             restart;

   assign restart = psel & penable & pwrite & pready & (paddr[ADDR_W-1:2] < CSR_COUNT);

   always_comb begin
      next_index_in = next_index_ff;
      if (restart) begin
         next_index_in = '0;
      end else if (rsp_valid && !rsp_stall) begin
         next_index_in = rsp_data.last_cell ? '0 : next_index_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_index_ff <= '0;
      end else begin
         next_index_ff <= next_index_in;
      end
   end

   a_reset_drains: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_pready_high: assert property (@(posedge clock) pready)
      else $error("pready dropped");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cell_index == next_index_ff)
      else $error("cell results out of raster order");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with the output free");

endmodule

bind block_average_binarizer bab_checker u_bab_checker (.*);
`default_nettype wire
